@@ hdl/ptsd_pkg.sv @@
// ----------------------------------------------------------------------------
// ptsd_pkg
// Shared types and constants of the point to segment distance pipeline.
// ----------------------------------------------------------------------------
package ptsd_pkg;

    localparam int COORD_W   = 32;
    localparam int DIFF_W    = COORD_W + 1;      // coordinate differences
    localparam int T_BITS    = 24;               // fraction bits of projection t
    localparam int LEN_W     = 67;               // squared length and remainder
    localparam int ROOT_BITS = 35;               // bits of the square root
    localparam int SQ_W      = 2 * ROOT_BITS + 1;
    localparam int DIST_W    = 33;
    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    typedef struct packed {
        logic                     vld;
        logic                     div_en;
        logic [LEN_W-1:0]         len2;
        logic [LEN_W-1:0]         rem;
        logic [T_BITS:0]          t;
        logic signed [DIFF_W-1:0] dx;
        logic signed [DIFF_W-1:0] dy;
        logic signed [DIFF_W-1:0] wx;
        logic signed [DIFF_W-1:0] wy;
    } div_word_t;

    typedef struct packed {
        logic                 vld;
        logic [SQ_W-1:0]      n;
        logic [ROOT_BITS-1:0] r;
    } sqrt_word_t;

endpackage

@@ hdl/point_to_segment_distance.sv @@
// ----------------------------------------------------------------------------
// point_to_segment_distance
// Distance from a point to a line segment, signed 16.16 in, unsigned 17.16 out.
// ----------------------------------------------------------------------------
// The block takes one query in every clock cycle (busy stays low) and gives
// its distance on distance with done high for one cycle; results leave in
// input order. The path runs through the chain: four setup stages (register,
// differences, products, sums), 24 division cells for the projection
// parameter, four stages for the nearest point residual and its square, 35
// square root cells and the output register.
module point_to_segment_distance (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    output logic                                   busy,
    input  logic signed [ptsd_pkg::COORD_W-1:0]    seg_start_x,
    input  logic signed [ptsd_pkg::COORD_W-1:0]    seg_start_y,
    input  logic signed [ptsd_pkg::COORD_W-1:0]    seg_end_x,
    input  logic signed [ptsd_pkg::COORD_W-1:0]    seg_end_y,
    input  logic signed [ptsd_pkg::COORD_W-1:0]    pt_x,
    input  logic signed [ptsd_pkg::COORD_W-1:0]    pt_y,
    output logic                                   done,
    output logic [ptsd_pkg::DIST_W-1:0]            distance
);
    import ptsd_pkg::*;

    localparam int LAT  = 4 + T_BITS + 4 + ROOT_BITS + 1;
    localparam int PR_W = T_BITS + 2 + DIFF_W;   // t times difference
    localparam int RX_W = PR_W - T_BITS;
    localparam int RQ_W = 2 * RX_W;

    // input register
    logic                      in_vld_reg;
    logic signed [COORD_W-1:0] sx_reg, sy_reg, ex_reg, ey_reg, px_reg, py_reg;
    // differences
    logic                      df_vld_reg;
    logic signed [DIFF_W-1:0]  dx_reg, dy_reg, wx_reg, wy_reg;
    // products
    logic                      pr_vld_reg;
    logic signed [2*DIFF_W-1:0] dxx_reg, dyy_reg, wdx_reg, wdy_reg;
    logic signed [DIFF_W-1:0]  pdx_reg, pdy_reg, pwx_reg, pwy_reg;
    // sums
    logic signed [LEN_W-1:0]   dot;
    logic [LEN_W-1:0]          len2;
    logic                      dot_pos;
    div_word_t                 div_head_next;
    div_word_t                 div_chain [0:T_BITS];
    // residual stages
    logic                      e1_vld_reg, e2_vld_reg, e3_vld_reg;
    logic signed [PR_W-1:0]    ox_reg, oy_reg;
    logic signed [DIFF_W-1:0]  e1_wx_reg, e1_wy_reg;
    logic signed [RX_W-1:0]    rx_reg, ry_reg;
    logic signed [RQ_W-1:0]    rxx_reg, ryy_reg;
    sqrt_word_t                sqrt_head_next;
    sqrt_word_t                sqrt_chain [0:ROOT_BITS];
    logic [ROOT_BITS-1:0]      root;
    logic                      done_reg;
    logic [DIST_W-1:0]         distance_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg <= 1'b0;
            df_vld_reg <= 1'b0;
            pr_vld_reg <= 1'b0;
        end
        else
        begin
            in_vld_reg <= start && !busy;
            df_vld_reg <= in_vld_reg;
            pr_vld_reg <= df_vld_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        sx_reg  <= seg_start_x;
        sy_reg  <= seg_start_y;
        ex_reg  <= seg_end_x;
        ey_reg  <= seg_end_y;
        px_reg  <= pt_x;
        py_reg  <= pt_y;
        dx_reg  <= DIFF_W'(ex_reg) - DIFF_W'(sx_reg);
        dy_reg  <= DIFF_W'(ey_reg) - DIFF_W'(sy_reg);
        wx_reg  <= DIFF_W'(px_reg) - DIFF_W'(sx_reg);
        wy_reg  <= DIFF_W'(py_reg) - DIFF_W'(sy_reg);
        dxx_reg <= dx_reg * dx_reg;
        dyy_reg <= dy_reg * dy_reg;
        wdx_reg <= wx_reg * dx_reg;
        wdy_reg <= wy_reg * dy_reg;
        pdx_reg <= dx_reg;
        pdy_reg <= dy_reg;
        pwx_reg <= wx_reg;
        pwy_reg <= wy_reg;
    end

    // pick the clamp case and seed the division chain
    always_comb
    begin
        len2    = LEN_W'($unsigned(dxx_reg)) + LEN_W'($unsigned(dyy_reg));
        dot     = LEN_W'(wdx_reg) + LEN_W'(wdy_reg);
        dot_pos = (len2 != '0) && (dot > 0);
        div_head_next.vld    = pr_vld_reg;
        div_head_next.div_en = dot_pos && ($unsigned(dot) < len2);
        div_head_next.len2   = len2;
        div_head_next.rem    = div_head_next.div_en ? $unsigned(dot) : '0;
        div_head_next.t      = (dot_pos && ($unsigned(dot) >= len2))
                             ? ((T_BITS+1)'(1) << T_BITS) : '0;
        div_head_next.dx     = pdx_reg;
        div_head_next.dy     = pdy_reg;
        div_head_next.wx     = pwx_reg;
        div_head_next.wy     = pwy_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            div_chain[0] <= '0;
        else
            div_chain[0] <= div_head_next;
    end

    for (genvar i = 0; i < T_BITS; i++)
    begin : g_div
        ptsd_div_cell u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .din  (div_chain[i]),
            .dout (div_chain[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e1_vld_reg <= 1'b0;
            e2_vld_reg <= 1'b0;
            e3_vld_reg <= 1'b0;
        end
        else
        begin
            e1_vld_reg <= div_chain[T_BITS].vld;
            e2_vld_reg <= e1_vld_reg;
            e3_vld_reg <= e2_vld_reg;
        end
    end

    // the arithmetic shift of t*d floors toward minus infinity
    always_ff @(posedge clk)
    begin
        ox_reg    <= $signed({1'b0, div_chain[T_BITS].t}) * div_chain[T_BITS].dx;
        oy_reg    <= $signed({1'b0, div_chain[T_BITS].t}) * div_chain[T_BITS].dy;
        e1_wx_reg <= div_chain[T_BITS].wx;
        e1_wy_reg <= div_chain[T_BITS].wy;
        rx_reg    <= RX_W'(e1_wx_reg) - ox_reg[PR_W-1:T_BITS];
        ry_reg    <= RX_W'(e1_wy_reg) - oy_reg[PR_W-1:T_BITS];
        rxx_reg   <= rx_reg * rx_reg;
        ryy_reg   <= ry_reg * ry_reg;
    end

    always_comb
    begin
        sqrt_head_next.vld = e3_vld_reg;
        sqrt_head_next.n   = SQ_W'($unsigned(rxx_reg)) + SQ_W'($unsigned(ryy_reg));
        sqrt_head_next.r   = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sqrt_chain[0] <= '0;
        else
            sqrt_chain[0] <= sqrt_head_next;
    end

    for (genvar j = 0; j < ROOT_BITS; j++)
    begin : g_sqrt
        ptsd_sqrt_cell #(.BIT(ROOT_BITS - 1 - j)) u_cell (
            .clk  (clk),
            .rst_n(rst_n),
            .din  (sqrt_chain[j]),
            .dout (sqrt_chain[j+1])
        );
    end

    assign root = sqrt_chain[ROOT_BITS].r;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= sqrt_chain[ROOT_BITS].vld;
    end

    // saturate the root to the output width
    always_ff @(posedge clk)
    begin
        if (root > ROOT_BITS'(DIST_MAX))
            distance_reg <= DIST_MAX;
        else
            distance_reg <= root[DIST_W-1:0];
    end

    assign done     = done_reg;
    assign distance = distance_reg;

`ifndef SYNTHESIS
    a_done_latency: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LAT))
        else $error("result strobe without a word taken at the pipeline depth");
    a_full_t_no_div: assert property (@(posedge clk) disable iff (!rst_n)
        (div_chain[0].vld && div_chain[0].div_en) |-> (div_chain[0].t == '0))
        else $error("division seeded with a nonzero projection");
`endif

endmodule

@@ hdl/ptsd_div_cell.sv @@
// ----------------------------------------------------------------------------
// ptsd_div_cell
// One restoring division step of the projection parameter.
// ----------------------------------------------------------------------------
module ptsd_div_cell (
    input  logic                clk,
    input  logic                rst_n,
    input  ptsd_pkg::div_word_t din,
    output ptsd_pkg::div_word_t dout
);
    import ptsd_pkg::*;

    div_word_t        word_reg;
    div_word_t        word_next;
    logic [LEN_W-1:0] rem2;
    logic             ge;

    always_comb
    begin
        rem2      = {din.rem[LEN_W-2:0], 1'b0};
        ge        = (rem2 >= din.len2);
        word_next = din;
        if (din.div_en)
        begin
            word_next.t   = {din.t[T_BITS-1:0], ge};
            word_next.rem = ge ? (rem2 - din.len2) : rem2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            word_reg <= '0;
        else
            word_reg <= word_next;
    end

    assign dout = word_reg;

`ifndef SYNTHESIS
    a_rem_below_len: assert property (@(posedge clk) disable iff (!rst_n)
        (word_reg.vld && word_reg.div_en) |-> (word_reg.rem < word_reg.len2))
        else $error("division remainder not below squared length");
`endif

endmodule

@@ hdl/ptsd_sqrt_cell.sv @@
// ----------------------------------------------------------------------------
// ptsd_sqrt_cell
// One digit of the integer square root, settling root bit BIT.
// ----------------------------------------------------------------------------
module ptsd_sqrt_cell #(
    parameter int BIT = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  ptsd_pkg::sqrt_word_t din,
    output ptsd_pkg::sqrt_word_t dout
);
    import ptsd_pkg::*;

    localparam logic [ROOT_BITS-1:0] LOW_MASK = ROOT_BITS'((64'd1 << BIT) - 64'd1);

    sqrt_word_t      word_reg;
    sqrt_word_t      word_next;
    logic [SQ_W-1:0] trial;
    logic            ge;

    always_comb
    begin
        // trial = 2*r*2^BIT + 2^(2*BIT), r holding only bits above BIT
        trial     = ({{(SQ_W-ROOT_BITS){1'b0}}, din.r} << (BIT + 1))
                  | (SQ_W'(1) << (2 * BIT));
        ge        = (din.n >= trial);
        word_next = din;
        if (ge)
        begin
            word_next.n = din.n - trial;
            word_next.r = din.r | (ROOT_BITS'(1) << BIT);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            word_reg <= '0;
        else
            word_reg <= word_next;
    end

    assign dout = word_reg;

`ifndef SYNTHESIS
    a_low_bits_clear: assert property (@(posedge clk) disable iff (!rst_n)
        word_reg.vld |-> ((word_reg.r & LOW_MASK) == '0))
        else $error("square root bits below the current digit are set");
`endif

endmodule

@@ tb/sv/tb.sv @@
// ----------------------------------------------------------------------------
// Point to segment distance testbench
// Streams segment/point queries through the distance pipeline. Each result is
// compared with a bit-exact local predictor: exact wide integer projection,
// the clamped t with 24 fraction bits, floor offsets and the floor square root.
// ----------------------------------------------------------------------------
module tb;
    import ptsd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 100;
    localparam int PHASE_LEN      = 160;

    typedef struct {
        logic signed [COORD_W-1:0] sx, sy, ex, ey, px, py;
    } query_t;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic signed [COORD_W-1:0] seg_start_x, seg_start_y, seg_end_x, seg_end_y;
    logic signed [COORD_W-1:0] pt_x, pt_y;
    logic                      done;
    logic [DIST_W-1:0]         distance;

    query_t            pending_q[$];
    logic [DIST_W-1:0] dist_expect_q[$];
    logic              took;
    int                sent_cnt;
    int                mismatch_cnt;
    int                quiet_cycles;
    bit                failed;

    point_to_segment_distance dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .seg_start_x (seg_start_x),
        .seg_start_y (seg_start_y),
        .seg_end_x   (seg_end_x),
        .seg_end_y   (seg_end_y),
        .pt_x        (pt_x),
        .pt_y        (pt_y),
        .done        (done),
        .distance    (distance)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic logic [DIST_W-1:0] seg_distance(query_t q);
        logic signed [127:0] dx, dy, wx, wy, dot, len2, t, rx, ry;
        logic        [127:0] sq, c, root;
        dx   = 128'(signed'(q.ex)) - 128'(signed'(q.sx));
        dy   = 128'(signed'(q.ey)) - 128'(signed'(q.sy));
        wx   = 128'(signed'(q.px)) - 128'(signed'(q.sx));
        wy   = 128'(signed'(q.py)) - 128'(signed'(q.sy));
        len2 = dx * dx + dy * dy;
        dot  = wx * dx + wy * dy;
        t    = 0;
        if (len2 != 0 && dot > 0)
        begin
            if (dot >= len2)
                t = 128'sd1 <<< T_BITS;
            else
                t = (dot <<< T_BITS) / len2;
        end
        // arithmetic shift floors the offset toward minus infinity
        rx   = wx - ((t * dx) >>> T_BITS);
        ry   = wy - ((t * dy) >>> T_BITS);
        sq   = rx * rx + ry * ry;
        root = 0;
        for (int b = ROOT_BITS - 1; b >= 0; b--)
        begin
            c = root | (128'd1 << b);
            if (c * c <= sq)
                root = c;
        end
        if (root > 128'(DIST_MAX))
            root = 128'(DIST_MAX);
        return root[DIST_W-1:0];
    endfunction

    function automatic query_t mk(int sx, int sy, int ex, int ey, int px, int py);
        query_t q;
        q.sx = sx; q.sy = sy; q.ex = ex; q.ey = ey; q.px = px; q.py = py;
        return q;
    endfunction

    function automatic int near_val(int base);
        return base + int'($urandom_range(0, 2000)) - 1000;
    endfunction

    function automatic query_t rand_query();
        query_t q;
        int     kind;
        kind = $urandom_range(0, 5);
        q = mk($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        case (kind)
            0: ;
            1:
            begin
                // small coordinates, a few units around the origin
                q = mk(int'($urandom_range(0, 1 << 20)) - (1 << 19),
                       int'($urandom_range(0, 1 << 20)) - (1 << 19),
                       int'($urandom_range(0, 1 << 20)) - (1 << 19),
                       int'($urandom_range(0, 1 << 20)) - (1 << 19),
                       int'($urandom_range(0, 1 << 20)) - (1 << 19),
                       int'($urandom_range(0, 1 << 20)) - (1 << 19));
            end
            2:
            begin
                q.ex = q.sx;
                q.ey = q.sy;
            end
            3:
            begin
                // point close to an endpoint
                q.px = near_val(q.ex);
                q.py = near_val(q.ey);
            end
            4:
            begin
                // nearly degenerate segment
                q.ex = near_val(q.sx);
                q.ey = near_val(q.sy);
            end
            default:
            begin
                q.sx = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
                q.ey = $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
            end
        endcase
        return q;
    endfunction

    initial
    begin
        int mx, mn;
        mx = 32'h7FFFFFFF;
        mn = 32'h80000000;
        pending_q.push_back(mk(0, 0, 0, 0, 0, 0));
        pending_q.push_back(mk(0, 0, 0, 0, mx, mx));
        pending_q.push_back(mk(mn, mn, mn, mn, mx, mx));
        pending_q.push_back(mk(mn, mn, mx, mx, mx, mn));
        pending_q.push_back(mk(mn, mx, mx, mn, mn, mn));
        pending_q.push_back(mk(mx, mx, mx, mx, mn, mn));
        pending_q.push_back(mk(mn, mn, mx, mx, mn, mn));
        pending_q.push_back(mk(mn, 0, mx, 0, 0, mx));
        pending_q.push_back(mk(0, 0, 65536, 0, 32768, 65536));
        pending_q.push_back(mk(0, 0, 65536, 0, 200000, 1));
        pending_q.push_back(mk(0, 0, 65536, 0, -200000, -1));
        pending_q.push_back(mk(0, 0, 65536, 0, 65536, 0));
        pending_q.push_back(mk(0, 0, 65536, 0, 0, 0));
        pending_q.push_back(mk(-65536, -65536, -3 * 65536, 5 * 65536, 7, -9));
        pending_q.push_back(mk(1, 1, 1, 1, -1, -1));
        pending_q.push_back(mk(0, 0, 3, 0, 1, 1));
        pending_q.push_back(mk(0, 0, -1, -1, -1, 0));
        pending_q.push_back(mk(-1, -1, -1, -1, -1, -1));
        pending_q.push_back(mk(0, 0, 0, 1, mn, mx));
        pending_q.push_back(mk(mx, mn, mn, mx, 0, 0));
        for (int i = 0; i < 600; i++)
            pending_q.push_back(rand_query());
    end

    // driver: present a new word after the previous one was taken
    always @(negedge clk or negedge rst_n)
    begin
        int idle_pct;
        if (!rst_n)
        begin
            start       <= 1'b0;
            seg_start_x <= '0;
            seg_start_y <= '0;
            seg_end_x   <= '0;
            seg_end_y   <= '0;
            pt_x        <= '0;
            pt_y        <= '0;
            sent_cnt    <= 0;
        end
        else if (!start || took)
        begin
            case ((sent_cnt / PHASE_LEN) % 4)
                0:       idle_pct = 0;
                1:       idle_pct = 80;
                2:       idle_pct = 0;
                default: idle_pct = 38;
            endcase
            if (pending_q.size() != 0 && $urandom_range(0, 99) >= idle_pct)
            begin
                seg_start_x <= pending_q[0].sx;
                seg_start_y <= pending_q[0].sy;
                seg_end_x   <= pending_q[0].ex;
                seg_end_y   <= pending_q[0].ey;
                pt_x        <= pending_q[0].px;
                pt_y        <= pending_q[0].py;
                start       <= 1'b1;
                sent_cnt    <= sent_cnt + 1;
                void'(pending_q.pop_front());
            end
            else
                start <= 1'b0;
        end
    end

    // monitor: record accepted words, check finished distances
    always @(posedge clk or negedge rst_n)
    begin
        logic [DIST_W-1:0] want;
        if (!rst_n)
        begin
            took         <= 1'b0;
            mismatch_cnt <= 0;
            quiet_cycles <= 0;
        end
        else
        begin
            took <= start && !busy;
            if (start && !busy)
                dist_expect_q.push_back(seg_distance(mk(seg_start_x, seg_start_y,
                    seg_end_x, seg_end_y, pt_x, pt_y)));
            if (done)
            begin
                if (dist_expect_q.size() == 0)
                begin
                    failed = 1'b1;
                    if (mismatch_cnt < 10)
                        $display("unexpected distance %0d", distance);
                    mismatch_cnt <= mismatch_cnt + 1;
                end
                else
                begin
                    want = dist_expect_q.pop_front();
                    if (distance !== want)
                    begin
                        failed = 1'b1;
                        if (mismatch_cnt < 10)
                            $display("distance mismatch: expected %0d actual %0d",
                                     want, distance);
                        mismatch_cnt <= mismatch_cnt + 1;
                    end
                end
            end
            if ((start && !busy) || done)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        failed = 1'b0;
        rst_n  = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        wait (pending_q.size() == 0 && !start && dist_expect_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (!failed && dist_expect_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
